>>> rtl/segx_pkg.sv
// Shared constants and types of the segment crossing datapath.
`timescale 1ns / 1ps
`default_nettype none
package segx_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int CW_MAX            = 29;

    localparam int XY_W  = 24;
    localparam int POS_W = 16;
    localparam int CNT_W = 2;
    localparam int TOL_W = 8;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_CROSS,
        MODE_POINT,
        MODE_COLL
    } mode_t;

endpackage
`default_nettype wire

>>> rtl/segx_delay.sv
// Fixed-length delay line for a valid bit and its side data.
`timescale 1ns / 1ps
`default_nettype none
module segx_delay #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_vld,
    input  logic [W-1:0] in_data,
    output logic         out_vld,
    output logic [W-1:0] out_data
);

    logic         vld_reg  [0:D-1];
    logic [W-1:0] data_reg [0:D-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < D; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < D; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_vld  = vld_reg[D-1];
    assign out_data = data_reg[D-1];

endmodule
`default_nettype wire

>>> rtl/segx_div.sv
// Pipelined signed fixed-point ratio unit: floor(num * 2^F / den), saturated to +-1.
`timescale 1ns / 1ps
`default_nettype none
module segx_div #(
    parameter int NUM_W  = 61,
    parameter int FRAC_W = 16
) (
    input  logic                     clk,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [NUM_W-1:0]  den,
    output logic signed [FRAC_W+1:0] quo
);

    localparam int RW = NUM_W + 1;
    localparam int QW = FRAC_W + 2;
    localparam logic signed [QW-1:0] ONE = QW'(1) << FRAC_W;

    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] dmag;

    logic [RW-1:0]     rem_reg [0:FRAC_W];
    logic [NUM_W-1:0]  d_reg   [0:FRAC_W];
    logic [FRAC_W-1:0] q_reg   [0:FRAC_W];
    logic              neg_reg [0:FRAC_W];
    logic              sat_reg [0:FRAC_W];

    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] quo_next;
    logic signed [QW-1:0] quo_reg;

    always_comb
    begin
        mag  = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
        dmag = den[NUM_W-1] ? $unsigned(-den) : $unsigned(den);
        // zero divisor only occurs for unused lanes
        if (den == '0)
        begin
            dmag = NUM_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {1'b0, mag};
        d_reg[0]   <= dmag;
        q_reg[0]   <= '0;
        neg_reg[0] <= num[NUM_W-1] ^ den[NUM_W-1];
        sat_reg[0] <= (mag >= dmag);
    end

    for (genvar i = 0; i < FRAC_W; i++)
    begin : g_step
        logic [RW-1:0] sh;
        logic          ge;

        assign sh = {rem_reg[i][RW-2:0], 1'b0};
        assign ge = (sh >= {1'b0, d_reg[i]});

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= ge ? (sh - {1'b0, d_reg[i]}) : sh;
            q_reg[i+1]   <= {q_reg[i][FRAC_W-2:0], ge};
            d_reg[i+1]   <= d_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            sat_reg[i+1] <= sat_reg[i];
        end
    end

    always_comb
    begin
        qx = $signed({2'b00, q_reg[FRAC_W]});
        if (sat_reg[FRAC_W])
        begin
            quo_next = neg_reg[FRAC_W] ? -ONE : ONE;
        end
        else if (neg_reg[FRAC_W])
        begin
            quo_next = -(qx + QW'(rem_reg[FRAC_W] != '0));
        end
        else
        begin
            quo_next = qx;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

>>> rtl/segment_intersection.sv
// Top level of the straight segment crossing pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Drive start high with the endpoints of AB (a_*, b_*) and MN (m_*, n_*) to
//   hand over an item. busy is always low, so an item is taken at every edge
//   where start is high; one item per cycle is sustained.
//   Each item yields one result, shown for a single cycle with done high:
//   cross_count (0..2) and up to two points with their positions along AB and
//   MN. Fields of a missing point read as zero.
//   On its way to done an item passes the two chained ratio units, each
//   POS_FRAC_BITS+2 stages deep; all but their input and output stages give
//   one quotient bit each.
//   snap_tolerance is written over cfg_valid/cfg_data (cfg_ready is always
//   high); the user writes it only while no item is in flight, which the block leaves unchecked.
//   Reset clears all valid bits and loads snap_tolerance with 1; items in
//   flight are dropped. The receiver cannot stall: every result is shown
//   exactly once.
module segment_intersection
#(
    parameter int COORD_BITS    = segx_pkg::COORD_BITS_DEF,
    parameter int POS_FRAC_BITS = segx_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_BITS-1:0]    a_x,
    input  logic signed [COORD_BITS-1:0]    a_y,
    input  logic signed [COORD_BITS-1:0]    b_x,
    input  logic signed [COORD_BITS-1:0]    b_y,
    input  logic signed [COORD_BITS-1:0]    m_x,
    input  logic signed [COORD_BITS-1:0]    m_y,
    input  logic signed [COORD_BITS-1:0]    n_x,
    input  logic signed [COORD_BITS-1:0]    n_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [segx_pkg::TOL_W-1:0]      cfg_data,
    output logic                            done,
    output logic [segx_pkg::CNT_W-1:0]      cross_count,
    output logic signed [segx_pkg::XY_W-1:0] first_x,
    output logic signed [segx_pkg::XY_W-1:0] first_y,
    output logic [segx_pkg::POS_W-1:0]      first_pos_ab,
    output logic [segx_pkg::POS_W-1:0]      first_pos_mn,
    output logic signed [segx_pkg::XY_W-1:0] second_x,
    output logic signed [segx_pkg::XY_W-1:0] second_y,
    output logic [segx_pkg::POS_W-1:0]      second_pos_ab,
    output logic [segx_pkg::POS_W-1:0]      second_pos_mn
);

    import segx_pkg::*;

    localparam int CW  = (COORD_BITS > CW_MAX) ? CW_MAX : COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PRW = 2 * DW;
    localparam int NW  = PRW + 1;
    localparam int P   = POS_FRAC_BITS;
    localparam int QW  = P + 2;
    localparam int PW  = P + 3;
    localparam int TW  = DW + QW;
    localparam int RXW = CW + 10;
    localparam int NW2 = RXW + 1;
    localparam int LAT = P + 2;

    localparam logic signed [PW-1:0] PONE = PW'(1) << P;

    function automatic logic adj_ok(input logic signed [PW-1:0] p,
                                    input logic signed [PW-1:0] t);
        return (p >= -t) && ((p <= t) || (p < PONE - t));
    endfunction

    function automatic logic signed [PW-1:0] adj_val(input logic signed [PW-1:0] p,
                                                     input logic signed [PW-1:0] t);
        return (p <= t) ? '0 : p;
    endfunction

    function automatic logic [XY_W-1:0] xy_out(input logic signed [RXW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[XY_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_out(input logic signed [PW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[POS_W-1:0];
    endfunction

    // ---------------- configuration
    logic [TOL_W-1:0]     tol_reg;
    logic signed [PW-1:0] tol_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign tol_s     = PW'(tol_reg);

    // ---------------- valid bits of the front and middle stages
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg;
    logic d1_vld, d2_vld;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= d1_vld;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= s8_vld_reg;
            done_reg   <= d2_vld;
        end
    end

    // ---------------- stage 1: capture item
    logic signed [CW-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [CW-1:0] s1_mx_reg, s1_my_reg, s1_nx_reg, s1_ny_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_ax_reg <= $signed(a_x[CW-1:0]);
            s1_ay_reg <= $signed(a_y[CW-1:0]);
            s1_bx_reg <= $signed(b_x[CW-1:0]);
            s1_by_reg <= $signed(b_y[CW-1:0]);
            s1_mx_reg <= $signed(m_x[CW-1:0]);
            s1_my_reg <= $signed(m_y[CW-1:0]);
            s1_nx_reg <= $signed(n_x[CW-1:0]);
            s1_ny_reg <= $signed(n_y[CW-1:0]);
        end
    end

    // ---------------- stage 2: differences
    logic signed [DW-1:0] s2_dbx_reg, s2_dby_reg, s2_dnx_reg, s2_dny_reg;
    logic signed [DW-1:0] s2_amx_reg, s2_amy_reg, s2_bmx_reg, s2_bmy_reg;
    logic signed [CW-1:0] s2_ax_reg, s2_ay_reg, s2_mx_reg, s2_my_reg;
    logic                 s2_abpt_reg, s2_mnpt_reg, s2_aeqm_reg;

    always_ff @(posedge clk)
    begin
        s2_dbx_reg  <= DW'(s1_bx_reg) - DW'(s1_ax_reg);
        s2_dby_reg  <= DW'(s1_by_reg) - DW'(s1_ay_reg);
        s2_dnx_reg  <= DW'(s1_nx_reg) - DW'(s1_mx_reg);
        s2_dny_reg  <= DW'(s1_ny_reg) - DW'(s1_my_reg);
        s2_amx_reg  <= DW'(s1_ax_reg) - DW'(s1_mx_reg);
        s2_amy_reg  <= DW'(s1_ay_reg) - DW'(s1_my_reg);
        s2_bmx_reg  <= DW'(s1_bx_reg) - DW'(s1_mx_reg);
        s2_bmy_reg  <= DW'(s1_by_reg) - DW'(s1_my_reg);
        s2_ax_reg   <= s1_ax_reg;
        s2_ay_reg   <= s1_ay_reg;
        s2_mx_reg   <= s1_mx_reg;
        s2_my_reg   <= s1_my_reg;
        s2_abpt_reg <= (s1_ax_reg == s1_bx_reg) && (s1_ay_reg == s1_by_reg);
        s2_mnpt_reg <= (s1_mx_reg == s1_nx_reg) && (s1_my_reg == s1_ny_reg);
        s2_aeqm_reg <= (s1_ax_reg == s1_mx_reg) && (s1_ay_reg == s1_my_reg);
    end

    // ---------------- stage 3: cross products, dominant axis
    logic [DW-1:0] abs_dbx, abs_dby, abs_dnx, abs_dny;

    assign abs_dbx = s2_dbx_reg[DW-1] ? $unsigned(-s2_dbx_reg) : $unsigned(s2_dbx_reg);
    assign abs_dby = s2_dby_reg[DW-1] ? $unsigned(-s2_dby_reg) : $unsigned(s2_dby_reg);
    assign abs_dnx = s2_dnx_reg[DW-1] ? $unsigned(-s2_dnx_reg) : $unsigned(s2_dnx_reg);
    assign abs_dny = s2_dny_reg[DW-1] ? $unsigned(-s2_dny_reg) : $unsigned(s2_dny_reg);

    logic signed [PRW-1:0] s3_p1_reg, s3_p2_reg, s3_p3_reg, s3_p4_reg, s3_p5_reg, s3_p6_reg;
    logic signed [DW-1:0]  s3_dbx_reg, s3_dby_reg, s3_dnx_reg, s3_dny_reg;
    logic signed [DW-1:0]  s3_amx_reg, s3_amy_reg, s3_bmx_reg, s3_bmy_reg;
    logic signed [CW-1:0]  s3_ax_reg, s3_ay_reg, s3_mx_reg, s3_my_reg;
    logic                  s3_abpt_reg, s3_mnpt_reg, s3_aeqm_reg, s3_abx_reg, s3_usex_reg;

    always_ff @(posedge clk)
    begin
        s3_p1_reg   <= s2_dbx_reg * s2_dny_reg;
        s3_p2_reg   <= s2_dby_reg * s2_dnx_reg;
        s3_p3_reg   <= s2_dbx_reg * s2_amy_reg;
        s3_p4_reg   <= s2_dby_reg * s2_amx_reg;
        s3_p5_reg   <= s2_dnx_reg * s2_amy_reg;
        s3_p6_reg   <= s2_dny_reg * s2_amx_reg;
        s3_dbx_reg  <= s2_dbx_reg;
        s3_dby_reg  <= s2_dby_reg;
        s3_dnx_reg  <= s2_dnx_reg;
        s3_dny_reg  <= s2_dny_reg;
        s3_amx_reg  <= s2_amx_reg;
        s3_amy_reg  <= s2_amy_reg;
        s3_bmx_reg  <= s2_bmx_reg;
        s3_bmy_reg  <= s2_bmy_reg;
        s3_ax_reg   <= s2_ax_reg;
        s3_ay_reg   <= s2_ay_reg;
        s3_mx_reg   <= s2_mx_reg;
        s3_my_reg   <= s2_my_reg;
        s3_abpt_reg <= s2_abpt_reg;
        s3_mnpt_reg <= s2_mnpt_reg;
        s3_aeqm_reg <= s2_aeqm_reg;
        s3_abx_reg  <= (abs_dbx > abs_dby);
        s3_usex_reg <= (abs_dnx > abs_dny);
    end

    // ---------------- stage 4: denominator and numerators
    logic signed [NW-1:0] s4_den_reg, s4_numt_reg, s4_nums_reg;
    logic                 s4_cola_reg, s4_colm_reg;
    logic signed [DW-1:0] s4_dbx_reg, s4_dby_reg, s4_dnx_reg, s4_dny_reg;
    logic signed [DW-1:0] s4_amx_reg, s4_amy_reg, s4_bmx_reg, s4_bmy_reg;
    logic signed [CW-1:0] s4_ax_reg, s4_ay_reg, s4_mx_reg, s4_my_reg;
    logic                 s4_abpt_reg, s4_mnpt_reg, s4_aeqm_reg, s4_abx_reg, s4_usex_reg;

    always_ff @(posedge clk)
    begin
        s4_den_reg  <= NW'(s3_p1_reg) - NW'(s3_p2_reg);
        s4_numt_reg <= NW'(s3_p3_reg) - NW'(s3_p4_reg);
        s4_nums_reg <= NW'(s3_p5_reg) - NW'(s3_p6_reg);
        s4_cola_reg <= (s3_p3_reg == s3_p4_reg);
        s4_colm_reg <= (s3_p6_reg == s3_p5_reg);
        s4_dbx_reg  <= s3_dbx_reg;
        s4_dby_reg  <= s3_dby_reg;
        s4_dnx_reg  <= s3_dnx_reg;
        s4_dny_reg  <= s3_dny_reg;
        s4_amx_reg  <= s3_amx_reg;
        s4_amy_reg  <= s3_amy_reg;
        s4_bmx_reg  <= s3_bmx_reg;
        s4_bmy_reg  <= s3_bmy_reg;
        s4_ax_reg   <= s3_ax_reg;
        s4_ay_reg   <= s3_ay_reg;
        s4_mx_reg   <= s3_mx_reg;
        s4_my_reg   <= s3_my_reg;
        s4_abpt_reg <= s3_abpt_reg;
        s4_mnpt_reg <= s3_mnpt_reg;
        s4_aeqm_reg <= s3_aeqm_reg;
        s4_abx_reg  <= s3_abx_reg;
        s4_usex_reg <= s3_usex_reg;
    end

    // ---------------- stage 5: case decision and ratio lane select
    mode_t                mode_next;
    logic signed [NW-1:0] l0n_next, l0d_next, l1n_next, l1d_next;

    always_comb
    begin
        if (s4_den_reg != '0)
        begin
            mode_next = MODE_CROSS;
        end
        else if (s4_mnpt_reg)
        begin
            mode_next = s4_cola_reg ? MODE_POINT : MODE_NONE;
        end
        else
        begin
            mode_next = s4_colm_reg ? MODE_COLL : MODE_NONE;
        end
    end

    always_comb
    begin
        case (mode_next)
            MODE_POINT:
            begin
                l0n_next = s4_abx_reg ? -NW'(s4_amx_reg) : -NW'(s4_amy_reg);
                l0d_next = s4_abx_reg ? NW'(s4_dbx_reg) : NW'(s4_dby_reg);
                l1n_next = l0n_next;
                l1d_next = l0d_next;
            end
            MODE_COLL:
            begin
                l0n_next = s4_usex_reg ? NW'(s4_amx_reg) : NW'(s4_amy_reg);
                l1n_next = s4_usex_reg ? NW'(s4_bmx_reg) : NW'(s4_bmy_reg);
                l0d_next = s4_usex_reg ? NW'(s4_dnx_reg) : NW'(s4_dny_reg);
                l1d_next = l0d_next;
            end
            default:
            begin
                l0n_next = s4_numt_reg;
                l0d_next = s4_den_reg;
                l1n_next = s4_nums_reg;
                l1d_next = s4_den_reg;
            end
        endcase
    end

    logic signed [NW-1:0] s5_l0n_reg, s5_l0d_reg, s5_l1n_reg, s5_l1d_reg;
    logic [4:0]           s5_flg_reg;
    logic [4*CW-1:0]      s5_crd_reg;
    logic [4*DW-1:0]      s5_dlt_reg;

    always_ff @(posedge clk)
    begin
        s5_l0n_reg <= l0n_next;
        s5_l0d_reg <= l0d_next;
        s5_l1n_reg <= l1n_next;
        s5_l1d_reg <= l1d_next;
        s5_flg_reg <= {mode_next, s4_abpt_reg, s4_aeqm_reg, s4_abx_reg};
        s5_crd_reg <= {s4_ax_reg, s4_ay_reg, s4_mx_reg, s4_my_reg};
        s5_dlt_reg <= {s4_dnx_reg, s4_dny_reg, s4_dbx_reg, s4_dby_reg};
    end

    // ---------------- first ratio units
    logic signed [QW-1:0] r0, r1;

    segx_div #(.NUM_W(NW), .FRAC_W(P)) u_div0 (
        .clk (clk),
        .num (s5_l0n_reg),
        .den (s5_l0d_reg),
        .quo (r0)
    );

    segx_div #(.NUM_W(NW), .FRAC_W(P)) u_div1 (
        .clk (clk),
        .num (s5_l1n_reg),
        .den (s5_l1d_reg),
        .quo (r1)
    );

    logic [4:0]      d1_flg;
    logic [4*CW-1:0] d1_crd;
    logic [4*DW-1:0] d1_dlt;
    logic            d1_vld_c, d1_vld_d;

    segx_delay #(.W(5), .D(LAT)) u_dly_flg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s5_vld_reg),
        .in_data  (s5_flg_reg),
        .out_vld  (d1_vld),
        .out_data (d1_flg)
    );

    segx_delay #(.W(4*CW), .D(LAT)) u_dly_crd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s5_vld_reg),
        .in_data  (s5_crd_reg),
        .out_vld  (d1_vld_c),
        .out_data (d1_crd)
    );

    segx_delay #(.W(4*DW), .D(LAT)) u_dly_dlt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s5_vld_reg),
        .in_data  (s5_dlt_reg),
        .out_vld  (d1_vld_d),
        .out_data (d1_dlt)
    );

    mode_t d1_mode;
    logic  d1_abpt, d1_aeqm;

    assign d1_mode = mode_t'(d1_flg[4:3]);
    assign d1_abpt = d1_flg[2];
    assign d1_aeqm = d1_flg[1];

    // ---------------- stage 6: position checks and point selection
    logic signed [PW-1:0] r0_e, r1_e, lo_e, hi_e;
    logic                 r0_ok, r1_ok, coll_ok, hi_in;
    logic signed [PW-1:0] tsel0_next, tsel1_next, pabfix_next;
    logic                 pre0_next, pre1_next, needdiv_next;

    always_comb
    begin
        r0_e    = PW'(r0);
        r1_e    = PW'(r1);
        r0_ok   = adj_ok(r0_e, tol_s);
        r1_ok   = adj_ok(r1_e, tol_s);
        lo_e    = (r0_e > r1_e) ? r1_e : r0_e;
        hi_e    = (r0_e > r1_e) ? r0_e : r1_e;
        coll_ok = !((lo_e >= PONE - tol_s) || (hi_e < -tol_s));
        hi_in   = (hi_e > tol_s) && (hi_e < PONE - tol_s);

        tsel0_next   = '0;
        tsel1_next   = '0;
        pabfix_next  = '0;
        pre0_next    = 1'b0;
        pre1_next    = 1'b0;
        needdiv_next = 1'b0;
        case (d1_mode)
            MODE_CROSS:
            begin
                tsel0_next  = adj_val(r0_e, tol_s);
                pabfix_next = adj_val(r1_e, tol_s);
                pre0_next   = r0_ok && r1_ok;
            end
            MODE_POINT:
            begin
                pre0_next   = d1_abpt ? d1_aeqm : r0_ok;
                pabfix_next = d1_abpt ? '0 : adj_val(r0_e, tol_s);
            end
            MODE_COLL:
            begin
                tsel0_next   = adj_val(lo_e, tol_s);
                tsel1_next   = hi_e;
                pre0_next    = coll_ok;
                pre1_next    = coll_ok && !d1_abpt && hi_in;
                needdiv_next = !d1_abpt;
            end
            default:
            begin
                pre0_next = 1'b0;
            end
        endcase
    end

    logic signed [QW-1:0] s6_t0_reg, s6_t1_reg, s6_pabfix_reg;
    logic                 s6_pre0_reg, s6_pre1_reg, s6_nd_reg, s6_abx_reg;
    logic [4*CW-1:0]      s6_crd_reg;
    logic [4*DW-1:0]      s6_dlt_reg;

    always_ff @(posedge clk)
    begin
        s6_t0_reg     <= QW'(tsel0_next);
        s6_t1_reg     <= QW'(tsel1_next);
        s6_pabfix_reg <= QW'(pabfix_next);
        s6_pre0_reg   <= pre0_next && d1_vld_c && d1_vld_d;
        s6_pre1_reg   <= pre1_next;
        s6_nd_reg     <= needdiv_next;
        s6_abx_reg    <= d1_flg[0];
        s6_crd_reg    <= d1_crd;
        s6_dlt_reg    <= d1_dlt;
    end

    logic signed [DW-1:0] s6_dnx, s6_dny;

    assign s6_dnx = $signed(s6_dlt_reg[4*DW-1 -: DW]);
    assign s6_dny = $signed(s6_dlt_reg[3*DW-1 -: DW]);

    // ---------------- stage 7: offsets along MN
    logic signed [TW-1:0] s7_px0_reg, s7_py0_reg, s7_px1_reg, s7_py1_reg;
    logic signed [QW-1:0] s7_t0_reg, s7_t1_reg, s7_pabfix_reg;
    logic                 s7_pre0_reg, s7_pre1_reg, s7_nd_reg, s7_abx_reg;
    logic [4*CW-1:0]      s7_crd_reg;
    logic [4*DW-1:0]      s7_dlt_reg;

    always_ff @(posedge clk)
    begin
        s7_px0_reg    <= s6_dnx * s6_t0_reg;
        s7_py0_reg    <= s6_dny * s6_t0_reg;
        s7_px1_reg    <= s6_dnx * s6_t1_reg;
        s7_py1_reg    <= s6_dny * s6_t1_reg;
        s7_t0_reg     <= s6_t0_reg;
        s7_t1_reg     <= s6_t1_reg;
        s7_pabfix_reg <= s6_pabfix_reg;
        s7_pre0_reg   <= s6_pre0_reg;
        s7_pre1_reg   <= s6_pre1_reg;
        s7_nd_reg     <= s6_nd_reg;
        s7_abx_reg    <= s6_abx_reg;
        s7_crd_reg    <= s6_crd_reg;
        s7_dlt_reg    <= s6_dlt_reg;
    end

    logic signed [CW-1:0] s7_mx, s7_my;

    assign s7_mx = $signed(s7_crd_reg[2*CW-1 -: CW]);
    assign s7_my = $signed(s7_crd_reg[CW-1 -: CW]);

    // ---------------- stage 8: point coordinates
    logic signed [RXW-1:0] s8_rx0_reg, s8_ry0_reg, s8_rx1_reg, s8_ry1_reg;
    logic signed [QW-1:0]  s8_t0_reg, s8_t1_reg, s8_pabfix_reg;
    logic                  s8_pre0_reg, s8_pre1_reg, s8_nd_reg, s8_abx_reg;
    logic signed [CW-1:0]  s8_ax_reg, s8_ay_reg;
    logic signed [DW-1:0]  s8_dbx_reg, s8_dby_reg;

    always_ff @(posedge clk)
    begin
        s8_rx0_reg    <= (RXW'(s7_mx) <<< 8) + RXW'(s7_px0_reg >>> (P - 8));
        s8_ry0_reg    <= (RXW'(s7_my) <<< 8) + RXW'(s7_py0_reg >>> (P - 8));
        s8_rx1_reg    <= (RXW'(s7_mx) <<< 8) + RXW'(s7_px1_reg >>> (P - 8));
        s8_ry1_reg    <= (RXW'(s7_my) <<< 8) + RXW'(s7_py1_reg >>> (P - 8));
        s8_t0_reg     <= s7_t0_reg;
        s8_t1_reg     <= s7_t1_reg;
        s8_pabfix_reg <= s7_pabfix_reg;
        s8_pre0_reg   <= s7_pre0_reg;
        s8_pre1_reg   <= s7_pre1_reg;
        s8_nd_reg     <= s7_nd_reg;
        s8_abx_reg    <= s7_abx_reg;
        s8_ax_reg     <= $signed(s7_crd_reg[4*CW-1 -: CW]);
        s8_ay_reg     <= $signed(s7_crd_reg[3*CW-1 -: CW]);
        s8_dbx_reg    <= $signed(s7_dlt_reg[2*DW-1 -: DW]);
        s8_dby_reg    <= $signed(s7_dlt_reg[DW-1 -: DW]);
    end

    // ---------------- stage 9: ratio lanes for positions along AB
    logic signed [NW2-1:0] s9_n0_reg, s9_n1_reg, s9_d_reg;
    logic [4*RXW-1:0]      s9_pts_reg;
    logic [3*QW-1:0]       s9_pos_reg;
    logic [2:0]            s9_flg_reg;

    always_ff @(posedge clk)
    begin
        s9_n0_reg  <= s8_abx_reg ? (NW2'(s8_rx0_reg) - (NW2'(s8_ax_reg) <<< 8))
                                 : (NW2'(s8_ry0_reg) - (NW2'(s8_ay_reg) <<< 8));
        s9_n1_reg  <= s8_abx_reg ? (NW2'(s8_rx1_reg) - (NW2'(s8_ax_reg) <<< 8))
                                 : (NW2'(s8_ry1_reg) - (NW2'(s8_ay_reg) <<< 8));
        s9_d_reg   <= s8_abx_reg ? (NW2'(s8_dbx_reg) <<< 8) : (NW2'(s8_dby_reg) <<< 8);
        s9_pts_reg <= {s8_rx0_reg, s8_ry0_reg, s8_rx1_reg, s8_ry1_reg};
        s9_pos_reg <= {s8_t0_reg, s8_t1_reg, s8_pabfix_reg};
        s9_flg_reg <= {s8_pre0_reg, s8_pre1_reg, s8_nd_reg};
    end

    logic signed [QW-1:0] q0, q1;

    segx_div #(.NUM_W(NW2), .FRAC_W(P)) u_div2 (
        .clk (clk),
        .num (s9_n0_reg),
        .den (s9_d_reg),
        .quo (q0)
    );

    segx_div #(.NUM_W(NW2), .FRAC_W(P)) u_div3 (
        .clk (clk),
        .num (s9_n1_reg),
        .den (s9_d_reg),
        .quo (q1)
    );

    logic [4*RXW-1:0] d2_pts;
    logic [3*QW-1:0]  d2_pos;
    logic [2:0]       d2_flg;
    logic             d2_vld_p, d2_vld_q;

    segx_delay #(.W(4*RXW), .D(LAT)) u_dly_pts (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s9_vld_reg),
        .in_data  (s9_pts_reg),
        .out_vld  (d2_vld_p),
        .out_data (d2_pts)
    );

    segx_delay #(.W(3*QW), .D(LAT)) u_dly_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s9_vld_reg),
        .in_data  (s9_pos_reg),
        .out_vld  (d2_vld_q),
        .out_data (d2_pos)
    );

    segx_delay #(.W(3), .D(LAT)) u_dly_fl2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s9_vld_reg),
        .in_data  (s9_flg_reg),
        .out_vld  (d2_vld),
        .out_data (d2_flg)
    );

    // ---------------- stage 10: final checks, compaction and output
    logic signed [PW-1:0]  q0_e, q1_e, pab0, pab1, pmn0, pmn1;
    logic signed [RXW-1:0] x0, y0, x1, y1;
    logic                  ok0, ok1;

    logic [CNT_W-1:0]      cnt_next;
    logic [XY_W-1:0]       fx_next, fy_next, sx_next, sy_next;
    logic [POS_W-1:0]      fab_next, fmn_next, sab_next, smn_next;

    always_comb
    begin
        q0_e = PW'(q0);
        q1_e = PW'(q1);
        x0   = $signed(d2_pts[4*RXW-1 -: RXW]);
        y0   = $signed(d2_pts[3*RXW-1 -: RXW]);
        x1   = $signed(d2_pts[2*RXW-1 -: RXW]);
        y1   = $signed(d2_pts[RXW-1 -: RXW]);
        pmn0 = PW'($signed(d2_pos[3*QW-1 -: QW]));
        pmn1 = PW'($signed(d2_pos[2*QW-1 -: QW]));
        pab0 = d2_flg[0] ? adj_val(q0_e, tol_s) : PW'($signed(d2_pos[QW-1 -: QW]));
        pab1 = adj_val(q1_e, tol_s);
        ok0  = d2_flg[2] && (!d2_flg[0] || adj_ok(q0_e, tol_s)) && d2_vld_p && d2_vld_q;
        ok1  = d2_flg[1] && adj_ok(q1_e, tol_s);

        cnt_next = '0;
        fx_next  = '0;
        fy_next  = '0;
        fab_next = '0;
        fmn_next = '0;
        sx_next  = '0;
        sy_next  = '0;
        sab_next = '0;
        smn_next = '0;
        if (ok0)
        begin
            fx_next  = xy_out(x0);
            fy_next  = xy_out(y0);
            fab_next = pos_out(pab0);
            fmn_next = pos_out(pmn0);
            cnt_next = CNT_W'(1);
            if (ok1)
            begin
                sx_next  = xy_out(x1);
                sy_next  = xy_out(y1);
                sab_next = pos_out(pab1);
                smn_next = pos_out(pmn1);
                cnt_next = CNT_W'(2);
            end
        end
        else if (ok1)
        begin
            // first point dropped: move the second one up
            fx_next  = xy_out(x1);
            fy_next  = xy_out(y1);
            fab_next = pos_out(pab1);
            fmn_next = pos_out(pmn1);
            cnt_next = CNT_W'(1);
        end
    end

    logic [CNT_W-1:0] cnt_reg;
    logic [XY_W-1:0]  fx_reg, fy_reg, sx_reg, sy_reg;
    logic [POS_W-1:0] fab_reg, fmn_reg, sab_reg, smn_reg;

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        fx_reg  <= fx_next;
        fy_reg  <= fy_next;
        fab_reg <= fab_next;
        fmn_reg <= fmn_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        sab_reg <= sab_next;
        smn_reg <= smn_next;
    end

    assign done          = done_reg;
    assign cross_count   = cnt_reg;
    assign first_x       = $signed(fx_reg);
    assign first_y       = $signed(fy_reg);
    assign first_pos_ab  = fab_reg;
    assign first_pos_mn  = fmn_reg;
    assign second_x      = $signed(sx_reg);
    assign second_y      = $signed(sy_reg);
    assign second_pos_ab = sab_reg;
    assign second_pos_mn = smn_reg;

endmodule
`default_nettype wire

>>> tb/tb_segment_intersection.sv
// Self-checking testbench of the segment crossing pipeline with a built-in crossing predictor.
`timescale 1ns / 1ps
module tb_segment_intersection;
    import segx_pkg::*;

    localparam int  LATENCY   = 46;
    localparam int  STALL_MAX = 5000;
    localparam longint ONE_Q  = 64'sd65536;

    typedef struct {
        logic [CNT_W-1:0]        cnt;
        logic signed [XY_W-1:0]  p0_x, p0_y;
        logic [POS_W-1:0]        p0_ab, p0_mn;
        logic signed [XY_W-1:0]  p1_x, p1_y;
        logic [POS_W-1:0]        p1_ab, p1_mn;
    } cross_t;

    typedef struct {
        shortint c[8];
        bit      typed;
        cross_t  want;
    } seg_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
    logic signed [15:0] m_x = '0, m_y = '0, n_x = '0, n_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;
    logic done;
    logic [CNT_W-1:0] cross_count;
    logic signed [XY_W-1:0] first_x, first_y, second_x, second_y;
    logic [POS_W-1:0] first_pos_ab, first_pos_mn, second_pos_ab, second_pos_mn;

    cross_t  pending_crossings[$];
    bit      typed_flags[$];
    cross_t  typed_wants[$];
    longint  tol_shadow = 1;
    int      errors = 0;
    int      stall_cycles = 0;
    bit      no_idle = 1'b0;

    segment_intersection DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
        .m_x(m_x), .m_y(m_y), .n_x(n_x), .n_y(n_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .cross_count(cross_count),
        .first_x(first_x), .first_y(first_y),
        .first_pos_ab(first_pos_ab), .first_pos_mn(first_pos_mn),
        .second_x(second_x), .second_y(second_y),
        .second_pos_ab(second_pos_ab), .second_pos_mn(second_pos_mn)
    );

    always #5 clk = ~clk;

    // floor(num * 2^16 / den), saturated to +-1.0
    function automatic longint ratio_q16(longint num, longint den);
        longint mag, rem, q;
        q = 0;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        mag = (num < 0) ? -num : num;
        if (mag >= den)
            return (num < 0) ? -ONE_Q : ONE_Q;
        rem = mag;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 1;
            end
        end
        if (num < 0)
            return -(q + ((rem != 0) ? 1 : 0));
        return q;
    endfunction

    function automatic bit snap_pos(ref longint p);
        if (p < -tol_shadow)
            return 1'b0;
        if (p <= tol_shadow)
        begin
            p = 0;
            return 1'b1;
        end
        return p < ONE_Q - tol_shadow;
    endfunction

    function automatic longint point_coord(longint base, longint delta, longint t);
        return base * 256 + ((delta * t) >>> 8);
    endfunction

    function automatic longint absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void put_slot(ref cross_t r, input int slot, input longint x,
                                     input longint y, input longint pab, input longint pmn);
        if (slot == 0)
        begin
            r.p0_x = x[XY_W-1:0]; r.p0_y = y[XY_W-1:0];
            r.p0_ab = pab[POS_W-1:0]; r.p0_mn = pmn[POS_W-1:0];
        end
        else
        begin
            r.p1_x = x[XY_W-1:0]; r.p1_y = y[XY_W-1:0];
            r.p1_ab = pab[POS_W-1:0]; r.p1_mn = pmn[POS_W-1:0];
        end
    endfunction

    function automatic cross_t predict_crossing(longint ax, longint ay, longint bx,
                                                longint by, longint mx, longint my,
                                                longint nx, longint ny);
        cross_t r;
        longint dbx, dby, dnx, dny, amx, amy, den, t, s, pab, rx, ry, h;
        longint tv[2];
        bit use_x, ab_point, ab_x;
        int npts, found;
        r = '{default: '0};
        found = 0;
        dbx = bx - ax; dby = by - ay; dnx = nx - mx; dny = ny - my;
        amx = ax - mx; amy = ay - my;
        den = dbx * dny - dby * dnx;
        if (den != 0)
        begin
            t = ratio_q16(dbx * amy - dby * amx, den);
            if (snap_pos(t))
            begin
                s = ratio_q16(dnx * amy - dny * amx, den);
                if (snap_pos(s))
                begin
                    put_slot(r, 0, point_coord(mx, dnx, t), point_coord(my, dny, t), s, t);
                    found = 1;
                end
            end
        end
        else if (mx == nx && my == ny)
        begin
            if (amy * dbx - amx * dby == 0)
            begin
                if (ax == bx && ay == by)
                begin
                    if (ax == mx && ay == my)
                    begin
                        put_slot(r, 0, mx * 256, my * 256, 0, 0);
                        found = 1;
                    end
                end
                else
                begin
                    s = (absl(dbx) > absl(dby)) ? ratio_q16(-amx, dbx) : ratio_q16(-amy, dby);
                    if (snap_pos(s))
                    begin
                        put_slot(r, 0, mx * 256, my * 256, s, 0);
                        found = 1;
                    end
                end
            end
        end
        else if (amx * dny - amy * dnx == 0)
        begin
            use_x = absl(dnx) > absl(dny);
            ab_point = (ax == bx && ay == by);
            ab_x = absl(dbx) > absl(dby);
            tv[0] = use_x ? ratio_q16(amx, dnx) : ratio_q16(amy, dny);
            tv[1] = use_x ? ratio_q16(bx - mx, dnx) : ratio_q16(by - my, dny);
            if (tv[0] > tv[1])
            begin
                h = tv[0]; tv[0] = tv[1]; tv[1] = h;
            end
            if (!(tv[0] >= ONE_Q - tol_shadow || tv[1] < -tol_shadow))
            begin
                if (tv[0] <= tol_shadow)
                    tv[0] = 0;
                npts = (!ab_point && tv[1] > tol_shadow && tv[1] < ONE_Q - tol_shadow) ? 2 : 1;
                for (int i = 0; i < npts; i++)
                begin
                    rx = point_coord(mx, dnx, tv[i]);
                    ry = point_coord(my, dny, tv[i]);
                    if (ab_point)
                        pab = 0;
                    else if (ab_x)
                        pab = ratio_q16(rx - ax * 256, dbx * 256);
                    else
                        pab = ratio_q16(ry - ay * 256, dby * 256);
                    if (snap_pos(pab))
                    begin
                        put_slot(r, found, rx, ry, pab, tv[i]);
                        found++;
                    end
                end
            end
        end
        r.cnt = found[CNT_W-1:0];
        return r;
    endfunction

    // accepted items: queue the expected crossing
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (typed_flags.size() > 0 && typed_flags.pop_front())
                pending_crossings.push_back(typed_wants.pop_front());
            else
                pending_crossings.push_back(predict_crossing(a_x, a_y, b_x, b_y,
                                                             m_x, m_y, n_x, n_y));
        end
    end

    task automatic check_field(string fname, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cross_t w;
        if (rst_n && done)
        begin
            if (pending_crossings.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding, count %0d", $time, cross_count);
            end
            else
            begin
                w = pending_crossings.pop_front();
                check_field("cross_count", w.cnt, cross_count);
                check_field("first_x", w.p0_x, first_x);
                check_field("first_y", w.p0_y, first_y);
                check_field("first_pos_ab", w.p0_ab, first_pos_ab);
                check_field("first_pos_mn", w.p0_mn, first_pos_mn);
                check_field("second_x", w.p1_x, second_x);
                check_field("second_y", w.p1_y, second_y);
                check_field("second_pos_ab", w.p1_ab, second_pos_ab);
                check_field("second_pos_mn", w.p1_mn, second_pos_mn);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("tb_segment_intersection: errors");
            $finish;
        end
    end

    task automatic send_item(shortint c[8]);
        a_x <= c[0]; a_y <= c[1]; b_x <= c[2]; b_y <= c[3];
        m_x <= c[4]; m_y <= c[5]; n_x <= c[6]; n_y <= c[7];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // unless no_idle is set, insert idle cycles so about a third of all cycles stay idle
        while (!no_idle && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tol_shadow = v;
    endtask

    function automatic shortint rnd_s(int lo, int hi);
        return shortint'($urandom_range(hi - lo) + lo);
    endfunction

    // random segment pair, biased toward collinear and degenerate geometry
    function automatic void random_pair(output shortint c[8]);
        int kind, px, py, dx, dy;
        int k[4];
        kind = $urandom_range(9);
        px = rnd_s(-1000, 1000); py = rnd_s(-1000, 1000);
        dx = rnd_s(-20, 20); dy = rnd_s(-20, 20);
        foreach (k[i])
            k[i] = rnd_s(-5, 5);
        case (kind)
            0, 1:
                foreach (c[i])
                    c[i] = shortint'($urandom());
            2:
                foreach (c[i])
                    c[i] = rnd_s(-8, 8);
            3, 4, 5:
            begin
                // collinear: four points along one line
                for (int i = 0; i < 4; i++)
                begin
                    c[2*i] = px + k[i] * dx;
                    c[2*i+1] = py + k[i] * dy;
                end
            end
            6:
            begin
                // point MN on the line of AB
                for (int i = 0; i < 3; i++)
                begin
                    c[2*i] = px + k[i] * dx;
                    c[2*i+1] = py + k[i] * dy;
                end
                c[6] = c[4]; c[7] = c[5];
            end
            7:
            begin
                // point AB against segment MN
                for (int i = 0; i < 4; i++)
                begin
                    c[2*i] = px + k[i] * dx;
                    c[2*i+1] = py + k[i] * dy;
                end
                c[2] = c[0]; c[3] = c[1];
                if (k[0][0])
                    c[0] = c[0] + 1;
                c[2] = c[0];
            end
            default:
                foreach (c[i])
                    c[i] = rnd_s(-2000, 2000);
        endcase
    endfunction

    seg_row_t directed_rows[$];

    function automatic seg_row_t mk_row(int ax, int ay, int bx, int by,
                                        int mx, int my, int nx, int ny);
        seg_row_t r;
        r.c = '{ax, ay, bx, by, mx, my, nx, ny};
        r.typed = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    initial
    begin
        seg_row_t row;
        shortint c[8];
        logic [TOL_W-1:0] tol_plan[4];

        // all four points equal at the origin
        row = mk_row(0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = 1'b1; row.want.cnt = 2'd1;
        directed_rows.push_back(row);
        // all four points equal elsewhere
        row = mk_row(5, 7, 5, 7, 5, 7, 5, 7);
        row.typed = 1'b1; row.want.cnt = 2'd1;
        row.want.p0_x = 24'sd1280; row.want.p0_y = 24'sd1792;
        directed_rows.push_back(row);
        // two different single points
        row = mk_row(1, 1, 1, 1, 2, 3, 2, 3);
        row.typed = 1'b1;
        directed_rows.push_back(row);
        // parallel, not collinear
        row = mk_row(0, 0, 10, 0, 0, 5, 10, 5);
        row.typed = 1'b1;
        directed_rows.push_back(row);
        directed_rows.push_back(mk_row(0, 0, 4, 4, 0, 4, 4, 0));
        directed_rows.push_back(mk_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        directed_rows.push_back(mk_row(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        directed_rows.push_back(mk_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        directed_rows.push_back(mk_row(0, 0, 10, 0, 4, 0, 20, 0));
        directed_rows.push_back(mk_row(0, 0, 20, 0, 4, 0, 8, 0));
        directed_rows.push_back(mk_row(4, 0, 8, 0, 0, 0, 20, 0));
        directed_rows.push_back(mk_row(20, 0, 0, 0, 0, 0, 20, 0));
        directed_rows.push_back(mk_row(0, 0, 10, 10, 10, 10, 20, 20));
        directed_rows.push_back(mk_row(0, 0, 10, 0, 10, 0, 10, 8));
        directed_rows.push_back(mk_row(0, 0, 10, 10, 3, 3, 3, 3));
        directed_rows.push_back(mk_row(0, 0, 10, 10, 3, 4, 3, 4));
        directed_rows.push_back(mk_row(0, 0, 10, 10, 10, 10, 10, 10));
        directed_rows.push_back(mk_row(2, 2, 2, 2, 0, 0, 8, 8));
        directed_rows.push_back(mk_row(2, 3, 2, 3, 0, 0, 8, 8));
        directed_rows.push_back(mk_row(0, 0, 3, 7, 1, 1, 1, 1));
        directed_rows.push_back(mk_row(0, 0, 5, 5, -5, 5, 5, -5));
        directed_rows.push_back(mk_row(0, 0, 3, 1, 0, 1, 3, 0));
        directed_rows.push_back(mk_row(-32768, -32768, 32767, 32767, -100, -100, 32767, 32767));
        directed_rows.push_back(mk_row(0, 0, 65535 - 65536, 1, 0, 1, -1, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        no_idle = 1'b0;
        foreach (directed_rows[i])
        begin
            typed_flags.push_back(directed_rows[i].typed);
            typed_wants.push_back(directed_rows[i].want);
            send_item(directed_rows[i].c);
        end

        tol_plan = '{8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'd1};
        foreach (tol_plan[p])
        begin
            write_tolerance(tol_plan[p]);
            for (int n = 0; n < 440; n++)
            begin
                no_idle = (p == 1 && n < 150);
                random_pair(c);
                send_item(c);
            end
        end
        no_idle = 1'b0;
        drain();

        if (errors == 0)
            $display("tb_segment_intersection: clean");
        else
            $display("tb_segment_intersection: errors");
        $finish;
    end

endmodule
